/* hdl/ssfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfe_pkg
// Shared types, command bytes and the segment font of the frame encoder.
// ----------------------------------------------------------------------------
package ssfe_pkg;

  localparam int unsigned PosW        = 4;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = 1;
  localparam int unsigned QueueCountW = 2;

  localparam logic [7:0] CmdWriteMode = 8'b0100_0000;
  localparam logic [7:0] CmdAddress0  = 8'b1100_0000;
  localparam logic [7:0] FillByte     = 8'hFF;
  localparam logic [7:0] ZeroByte     = 8'h00;

  localparam logic [7:0] SegA = 8'b0000_0001;
  localparam logic [7:0] SegB = 8'b0000_0010;
  localparam logic [7:0] SegC = 8'b0000_0100;
  localparam logic [7:0] SegE = 8'b0000_1000;
  localparam logic [7:0] SegD = 8'b0001_0000;
  localparam logic [7:0] SegF = 8'b0010_0000;
  localparam logic [7:0] SegG = 8'b0100_0000;

  // One classified request handed from the front to the back
  typedef struct packed {
    logic            hdr;      // open a frame with both commands
    logic            is_char;  // segment byte and fill, else padding
    logic            closes;   // digit limit reached: append trailing zero
    logic [7:0]      seg;
    logic [PosW-1:0] pad;      // blank digits to pad on a terminator
  } ssfe_desc_t;

  function automatic logic [7:0] ssfe_font(input logic [7:0] ch);
    logic [7:0] s;
    unique case (ch)
      "0":      s = SegA | SegB | SegC | SegD | SegE | SegF;
      "1":      s = SegB | SegC;
      "2":      s = SegA | SegB | SegG | SegE | SegD;
      "3":      s = SegA | SegB | SegC | SegD | SegG;
      "4":      s = SegF | SegG | SegB | SegC;
      "5":      s = SegA | SegF | SegG | SegC | SegD;
      "6":      s = SegA | SegF | SegE | SegD | SegC | SegG;
      "7":      s = SegA | SegB | SegC;
      "8":      s = SegA | SegB | SegC | SegD | SegE | SegF | SegG;
      "9":      s = SegA | SegB | SegC | SegD | SegF | SegG;
      "-":      s = SegG;
      "A", "a": s = SegA | SegB | SegC | SegF | SegE | SegG;
      "B", "b": s = SegF | SegE | SegG | SegC | SegD;
      "C", "c": s = SegA | SegF | SegE | SegD;
      "D", "d": s = SegB | SegC | SegD | SegE | SegG;
      "E", "e": s = SegA | SegG | SegD | SegF | SegE;
      "F", "f": s = SegA | SegG | SegF | SegE;
      "P", "p": s = SegA | SegB | SegF | SegE | SegG;
      "R", "r": s = SegE | SegG;
      "O", "o": s = SegE | SegG | SegC | SegD;
      "G", "g": s = SegE | SegF | SegA | SegD | SegC;
      "I", "i": s = SegE;
      "S", "s": s = SegD | SegC | SegG | SegF | SegA;
      "L", "l": s = SegE | SegF | SegD;
      ".", ",": s = SegE;
      default:  s = ZeroByte;
    endcase
    return s;
  endfunction

endpackage

/* hdl/seven_segment_frame_encoder_unit.sv */
`timescale 1ns / 1ps
// The first byte of a character passes the request queue, the back sequencer's request
// register and the output register before it shows on the result side.
// Throughput: one byte per cycle from the back sequencer while the receiver pops, so a plain
// character gives two bytes, a frame opener four, and a terminator up to 3 + 2*DIGITS bytes.
// The two-entry request queue lets the front keep accepting while the back expands bytes.
// Reset clears the digit position, the discard flag, the queue and the output register.
// ----------------------------------------------------------------------------
// seven_segment_frame_encoder_unit
// Turns a character string into seven-segment driver frames.
// ----------------------------------------------------------------------------
module seven_segment_frame_encoder_unit import ssfe_pkg::*; #(
  parameter int unsigned DIGITS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] character_i,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] frame_byte_o,
  output logic       frame_start_o,
  output logic       frame_end_o,
  output logic       run_last_o
);

  logic       accept, wr, q_valid, q_rd;
  ssfe_desc_t wdesc, rdesc;

  assign accept = push && !full;

  ssfe_front #(.DIGITS(DIGITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .character_i (character_i),
    .wr_o        (wr),
    .desc_o      (wdesc)
  );

  ssfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .wdata_i (wdesc),
    .rd_i    (q_rd),
    .rdata_o (rdesc),
    .valid_o (q_valid),
    .full_o  (full)
  );

  ssfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_desc_i      (rdesc),
    .q_rd_o        (q_rd),
    .pop           (pop),
    .empty         (empty),
    .frame_byte_o  (frame_byte_o),
    .frame_start_o (frame_start_o),
    .frame_end_o   (frame_end_o),
    .run_last_o    (run_last_o)
  );

endmodule

/* hdl/ssfe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfe_front
// Accepts characters, tracks the digit position and classifies each one.
// ----------------------------------------------------------------------------
module ssfe_front import ssfe_pkg::*; #(
  parameter int unsigned DIGITS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] character_i,
  output logic       wr_o,
  output ssfe_desc_t desc_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            disc_q, disc_d;
  logic [PosW-1:0] pos_inc;
  logic            is_char;

  assign is_char = (character_i != 8'd0);
  assign pos_inc = pos_q + PosW'(1);

  always_comb begin
    pos_d          = pos_q;
    disc_d         = disc_q;
    wr_o           = accept_i && !disc_q;
    desc_o.hdr     = (pos_q == '0);
    desc_o.is_char = is_char;
    desc_o.closes  = is_char && (pos_inc >= PosW'(DIGITS));
    desc_o.seg     = ssfe_font(character_i);
    desc_o.pad     = PosW'(DIGITS) - pos_q;
    if (accept_i) begin
      if (disc_q) begin
        // drop characters up to and including the terminator
        if (!is_char) disc_d = 1'b0;
      end else if (is_char) begin
        pos_d  = desc_o.closes ? '0 : pos_inc;
        disc_d = desc_o.closes;
      end else begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      disc_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      disc_q <= disc_d;
    end
  end

  a_disc_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (pos_q == '0))
    else $error("discarding with a frame open");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosW'(DIGITS))
    else $error("digit position beyond limit");

endmodule

/* hdl/ssfe_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfe_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module ssfe_queue import ssfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  ssfe_desc_t wdata_i,
  input  logic       rd_i,
  output ssfe_desc_t rdata_o,
  output logic       valid_o,
  output logic       full_o
);

  ssfe_desc_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, rptr_q;
  logic [QueueCountW-1:0] count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == QueueCountW'(QueueDepth));
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + QueuePtrW'(1);
      if (rd_i) rptr_q <= rptr_q + QueuePtrW'(1);
      if (wr_i && !rd_i)      count_q <= count_q + QueueCountW'(1);
      else if (rd_i && !wr_i) count_q <= count_q - QueueCountW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i || rd_i)
    else $error("write to a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> valid_o)
    else $error("read from an empty queue");

endmodule

/* hdl/ssfe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfe_back
// Expands each request into frame bytes, one byte per cycle while the output is free or popped.
// ----------------------------------------------------------------------------
module ssfe_back import ssfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  ssfe_desc_t q_desc_i,
  output logic       q_rd_o,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] frame_byte_o,
  output logic       frame_start_o,
  output logic       frame_end_o,
  output logic       run_last_o
);

  typedef enum logic [2:0] {
    PhHdr0, PhHdr1, PhSeg, PhFill, PhPad, PhTail
  } phase_e;

  phase_e            phase_q, phase_d, first_ph, after_hdr;
  ssfe_desc_t        cur_q;
  logic              busy_q, busy_d;
  logic [PosW:0]     cnt_q, cnt_d;
  logic              out_valid_q;
  logic [7:0]        byte_q, byte_d;
  logic              start_q, start_d, end_q, end_d, last_q, last_d;
  logic              adv, emit, load;

  assign adv   = !out_valid_q || pop;
  assign emit  = busy_q && adv;
  assign load  = q_valid_i && (!busy_q || (emit && last_d));
  assign q_rd_o = load;

  assign empty         = !out_valid_q;
  assign frame_byte_o  = byte_q;
  assign frame_start_o = start_q;
  assign frame_end_o   = end_q;
  assign run_last_o    = last_q;

  always_comb begin
    after_hdr = cur_q.is_char ? PhSeg : ((cur_q.pad != '0) ? PhPad : PhTail);
    if (q_desc_i.hdr)          first_ph = PhHdr0;
    else if (q_desc_i.is_char) first_ph = PhSeg;
    else if (q_desc_i.pad != '0) first_ph = PhPad;
    else                       first_ph = PhTail;
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    byte_d  = ZeroByte;
    start_d = 1'b0;
    end_d   = 1'b0;
    last_d  = 1'b0;
    unique case (phase_q)
      PhHdr0: begin
        byte_d  = CmdWriteMode;
        start_d = 1'b1;
        phase_d = PhHdr1;
      end
      PhHdr1: begin
        byte_d  = CmdAddress0;
        phase_d = after_hdr;
      end
      PhSeg: begin
        byte_d  = cur_q.seg;
        phase_d = PhFill;
      end
      PhFill: begin
        byte_d  = FillByte;
        last_d  = !cur_q.closes;
        phase_d = PhTail;
      end
      PhPad: begin
        cnt_d = cnt_q - (PosW+1)'(1);
        if (cnt_q == (PosW+1)'(1)) phase_d = PhTail;
      end
      PhTail: begin
        end_d  = 1'b1;
        last_d = 1'b1;
      end
      default: phase_d = PhTail;
    endcase
    busy_d = busy_q && !(emit && last_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PhHdr0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      cnt_q       <= '0;
      byte_q      <= ZeroByte;
      start_q     <= 1'b0;
      end_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (adv) out_valid_q <= busy_q;
      if (load) begin
        busy_q  <= 1'b1;
        phase_q <= first_ph;
        cur_q   <= q_desc_i;
        cnt_q   <= {q_desc_i.pad, 1'b0};
      end else begin
        busy_q <= busy_d;
        if (emit) begin
          phase_q <= phase_d;
          cnt_q   <= cnt_d;
        end
      end
      if (emit) begin
        byte_q  <= byte_d;
        start_q <= start_d;
        end_q   <= end_d;
        last_q  <= last_d;
      end
    end
  end

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> run_last_o)
    else $error("frame end not on last result of its item");

  a_start_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_start_o) |-> (frame_byte_o == CmdWriteMode))
    else $error("frame start without write-mode command");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seven-segment frame encoder. Strings are fed
// one character per request; an in-bench model of the frame layout predicts
// every byte with its start, end and run-last flags, and the monitor checks
// each popped byte against the oldest prediction. The run steps through
// phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import ssfe_pkg::*;

  localparam int unsigned Digits = 6;

  typedef struct packed {
    logic [7:0] value;
    logic       opens;
    logic       closes;
    logic       run_last;
  } frame_entry_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] character_i = '0;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] frame_byte_o;
  logic       frame_start_o;
  logic       frame_end_o;
  logic       run_last_o;

  logic [7:0]   pending_chars[$];
  frame_entry_t frame_bytes_due[$];

  logic [PosW-1:0] digits_written = '0;
  logic            dropping_chars = 1'b0;
  bit              char_taken = 1'b0;
  int unsigned     send_gap_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     error_count = 0;

  string alphabet = "0123456789-AaBbCcDdEeFfGgIiLlOoPpRrSs.,";

  seven_segment_frame_encoder_unit #(
    .DIGITS(Digits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .character_i  (character_i),
    .pop          (pop),
    .empty        (empty),
    .frame_byte_o (frame_byte_o),
    .frame_start_o(frame_start_o),
    .frame_end_o  (frame_end_o),
    .run_last_o   (run_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] segment_pattern(input logic [7:0] ch);
    logic [7:0] c;
    // fold upper case onto lower case, the font treats both alike
    c = (ch >= "A" && ch <= "Z") ? (ch | 8'h20) : ch;
    case (c)
      "0":      return SegA | SegB | SegC | SegD | SegE | SegF;
      "1":      return SegB | SegC;
      "2":      return SegA | SegB | SegD | SegE | SegG;
      "3":      return SegA | SegB | SegC | SegD | SegG;
      "4":      return SegB | SegC | SegF | SegG;
      "5":      return SegA | SegC | SegD | SegF | SegG;
      "6":      return SegA | SegC | SegD | SegE | SegF | SegG;
      "7":      return SegA | SegB | SegC;
      "8":      return SegA | SegB | SegC | SegD | SegE | SegF | SegG;
      "9":      return SegA | SegB | SegC | SegD | SegF | SegG;
      "-":      return SegG;
      "a":      return SegA | SegB | SegC | SegE | SegF | SegG;
      "b":      return SegC | SegD | SegE | SegF | SegG;
      "c":      return SegA | SegD | SegE | SegF;
      "d":      return SegB | SegC | SegD | SegE | SegG;
      "e":      return SegA | SegD | SegE | SegF | SegG;
      "f":      return SegA | SegE | SegF | SegG;
      "g":      return SegA | SegC | SegD | SegE | SegF;
      "i":      return SegE;
      "l":      return SegD | SegE | SegF;
      "o":      return SegC | SegD | SegE | SegG;
      "p":      return SegA | SegB | SegE | SegF | SegG;
      "r":      return SegE | SegG;
      "s":      return SegA | SegC | SegD | SegF | SegG;
      ".", ",": return SegE;
      default:  return ZeroByte;
    endcase
  endfunction

  // Work out the bytes one accepted character produces and queue them
  task automatic encode_character(input logic [7:0] ch);
    frame_entry_t run[16];
    int n;
    n = 0;
    if (dropping_chars) begin
      if (ch == 8'h00) dropping_chars = 1'b0;
      return;
    end
    if (digits_written == '0) begin
      run[n] = '{CmdWriteMode, 1'b1, 1'b0, 1'b0}; n++;
      run[n] = '{CmdAddress0, 1'b0, 1'b0, 1'b0}; n++;
    end
    if (ch != 8'h00) begin
      run[n] = '{segment_pattern(ch), 1'b0, 1'b0, 1'b0}; n++;
      run[n] = '{FillByte, 1'b0, 1'b0, 1'b0}; n++;
      digits_written = digits_written + PosW'(1);
      if (digits_written >= PosW'(Digits)) begin
        run[n] = '{ZeroByte, 1'b0, 1'b1, 1'b0}; n++;
        digits_written = '0;
        dropping_chars = 1'b1;
      end
    end else begin
      // blank out every digit not yet written
      for (int p = digits_written; p < Digits; p++) begin
        run[n] = '{ZeroByte, 1'b0, 1'b0, 1'b0}; n++;
        run[n] = '{ZeroByte, 1'b0, 1'b0, 1'b0}; n++;
      end
      run[n] = '{ZeroByte, 1'b0, 1'b1, 1'b0}; n++;
      digits_written = '0;
    end
    run[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) frame_bytes_due.push_back(run[i]);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t tb_top mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Drive the request side and the pop strobe away from the sampling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (push && !char_taken) begin
        // hold the request until it is taken
      end else if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        push        <= 1'b1;
        character_i <= pending_chars[0];
      end else begin
        push        <= 1'b0;
        character_i <= 8'($urandom);
      end
    end
  end

  always @(posedge clk_i) begin
    frame_entry_t want;
    char_taken = 1'b0;
    if (rst_ni) begin
      if (push && !full) begin
        char_taken = 1'b1;
        void'(pending_chars.pop_front());
        encode_character(character_i);
      end
      if (pop && !empty) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", frame_byte_o));
        end else begin
          want = frame_bytes_due.pop_front();
          if (frame_byte_o !== want.value)
            report_mismatch($sformatf("frame_byte %02h, want %02h", frame_byte_o, want.value));
          if (frame_start_o !== want.opens)
            report_mismatch($sformatf("frame_start %b, want %b", frame_start_o, want.opens));
          if (frame_end_o !== want.closes)
            report_mismatch($sformatf("frame_end %b, want %b", frame_end_o, want.closes));
          if (run_last_o !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b", run_last_o, want.run_last));
        end
      end
    end
  end

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
    pending_chars.push_back(8'h00);
  endtask

  // One NUL-terminated string with random content; returns characters queued
  task automatic queue_random_string(output int counted);
    int len;
    logic [7:0] ch;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, Digits);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) ch = 8'($urandom_range(1, 255));
      else ch = alphabet[$urandom_range(0, alphabet.len() - 1)];
      pending_chars.push_back(ch);
    end
    pending_chars.push_back(8'h00);
    counted = len + 1;
  endtask

  initial begin
    int unsigned send_plan[4];
    int unsigned recv_plan[4];
    int counted;
    int phase_items;
    send_plan = '{0, 47, 0, 35};
    recv_plan = '{0, 0, 47, 35};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct   = send_plan[ph];
      recv_stall_pct = recv_plan[ph];
      if (ph == 0) begin
        queue_text("");           // empty string: a whole blank frame
        queue_text("01234");      // one digit left to pad
        queue_text("56789-x");    // limit reached, trailing char dropped
        queue_text("gIlOpr");
        pending_chars.push_back(8'hFF);
        pending_chars.push_back(8'h80);
        pending_chars.push_back(8'h00);
      end
      phase_items = 0;
      while (phase_items < 100) begin
        queue_random_string(counted);
        phase_items += counted;
      end
      while (pending_chars.size() != 0 || frame_bytes_due.size() != 0) @(negedge clk_i);
    end
    repeat (40) @(negedge clk_i);
    if (error_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* seven_segment_frame_encoder_unit.f */
hdl/ssfe_pkg.sv
hdl/ssfe_front.sv
hdl/ssfe_queue.sv
hdl/ssfe_back.sv
hdl/seven_segment_frame_encoder_unit.sv
dv/tb_top.sv
